// ===== hw/rtl/hth_pkg.sv =====
`default_nettype none

package hth_pkg;

	// Default sizing of the table and of the stored fields.
	localparam int unsigned DEF_MAX_ENTRIES = 65536;
	localparam int unsigned DEF_SCORE_BITS  = 16;
	localparam int unsigned DEF_MOVE_BITS   = 32;

	localparam int unsigned KEY_BITS    = 64;
	localparam int unsigned TAG_BITS    = 32;
	localparam int unsigned DEPTH_BITS  = 8;
	localparam int unsigned PLY_BITS    = 8;
	localparam int unsigned HITS_BITS   = 32;
	localparam int unsigned ENTRY_BITS  = 17;
	localparam int unsigned MATE_BITS   = 15;

	// Request codes.
	localparam logic [1:0] KIND_PROBE = 2'd0;
	localparam logic [1:0] KIND_SAVE  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	// Bound codes.
	localparam logic [1:0] BOUND_NONE  = 2'd0;
	localparam logic [1:0] BOUND_EXACT = 2'd1;
	localparam logic [1:0] BOUND_LOWER = 2'd2;
	localparam logic [1:0] BOUND_UPPER = 2'd3;

	// Configuration register indexes.
	localparam logic CFG_TABLE_ENTRIES  = 1'b0;
	localparam logic CFG_MATE_THRESHOLD = 1'b1;

	localparam logic [ENTRY_BITS-1:0] RST_TABLE_ENTRIES  = 17'd65536;
	localparam logic [MATE_BITS-1:0]  RST_MATE_THRESHOLD = 15'd31000;

endpackage

`default_nettype wire

// ===== hw/rtl/hashed_transposition_table_top.sv =====
// Channel   Signals                                         Direction  Handshake
// request   start, busy, kind, search_key, move_in,         in         start & !busy
//           score_in, bound_in, depth_in, ply
// result    done, found, score_out, depth_out, move_out,    out        done, one cycle
//           bound_out, hits
// config    cfg_valid, cfg_ready, cfg_index, cfg_data        in         cfg_valid & cfg_ready
//
// A probe or save runs as key multiply at accept, index and table read, then
// update; busy is low again the cycle after the update, and a probe result is on
// the ports in that cycle.
// A clear writes one entry per cycle, from slot zero up to the last slot.
// After reset the same clearing pass runs with busy high; configuration writes are
// taken at any time. The receiver cannot stall results.

`default_nettype none

module hashed_transposition_table_top
	import hth_pkg::*;
#(
	parameter int unsigned MAX_ENTRIES = DEF_MAX_ENTRIES,
	parameter int unsigned SCORE_BITS  = DEF_SCORE_BITS,
	parameter int unsigned MOVE_BITS   = DEF_MOVE_BITS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,

	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [1:0]                   kind,
	input  wire logic [KEY_BITS-1:0]          search_key,
	input  wire logic [MOVE_BITS-1:0]         move_in,
	input  wire logic signed [SCORE_BITS-1:0] score_in,
	input  wire logic [1:0]                   bound_in,
	input  wire logic [DEPTH_BITS-1:0]        depth_in,
	input  wire logic [PLY_BITS-1:0]          ply,

	output logic                              done,
	output logic                              found,
	output logic signed [SCORE_BITS-1:0]      score_out,
	output logic [DEPTH_BITS-1:0]             depth_out,
	output logic [MOVE_BITS-1:0]              move_out,
	output logic [1:0]                        bound_out,
	output logic [HITS_BITS-1:0]              hits,

	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic                         cfg_index,
	input  wire logic [ENTRY_BITS-1:0]        cfg_data
);

	localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned NW = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned PW = TAG_BITS + NW;
	localparam int unsigned AW = ((SCORE_BITS > 16) ? SCORE_BITS : 16) + 2;
	localparam logic [IW-1:0] LAST_SLOT = IW'(MAX_ENTRIES - 1);
	localparam logic signed [AW-1:0] SMAX =
		signed'(AW'((64'd1 << (SCORE_BITS - 1)) - 64'd1));
	localparam logic signed [AW-1:0] SMIN = -SMAX - AW'(1);

	typedef struct packed {
		logic [TAG_BITS-1:0]          tag;
		logic [MOVE_BITS-1:0]         move;
		logic signed [SCORE_BITS-1:0] score;
		logic [DEPTH_BITS-1:0]        depth;
		logic [1:0]                   bound;
	} entry_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_UPDATE,
		S_CLEAR
	} state_t;

	state_t                       state_q;
	logic [IW-1:0]                clr_ptr_q;
	logic [ENTRY_BITS-1:0]        entries_q;
	logic [MATE_BITS-1:0]         mate_q;
	logic [HITS_BITS-1:0]         hits_q;

	logic                         save_q;
	logic [TAG_BITS-1:0]          tag_q;
	logic [MOVE_BITS-1:0]         move_q;
	logic signed [SCORE_BITS-1:0] score_q;
	logic [1:0]                   bound_q;
	logic [DEPTH_BITS-1:0]        depth_q;
	logic [PLY_BITS-1:0]          ply_q;
	logic [PW-1:0]                prod_hi_s1;
	logic [PW-1:0]                prod_lo_s1;
	logic [IW-1:0]                idx_s2;
	entry_t                       rdata_s2;

	logic                         done_q;
	logic                         found_q;
	logic signed [SCORE_BITS-1:0] score_out_q;
	logic [DEPTH_BITS-1:0]        depth_out_q;
	logic [MOVE_BITS-1:0]         move_out_q;
	logic [1:0]                   bound_out_q;

	entry_t                       mem [MAX_ENTRIES];

	logic [NW-1:0]                n_sat;
	logic [PW-1:0]                prod_hi_w;
	logic [PW-1:0]                prod_lo_w;
	logic [PW:0]                  mid_w;
	logic [IW-1:0]                idx_w;
	logic                         accept;
	logic                         hit_w;
	logic signed [AW-1:0]         sw;
	logic signed [AW-1:0]         thr_w;
	logic signed [AW-1:0]         ply_w;
	logic signed [AW-1:0]         adj_w;
	logic signed [SCORE_BITS-1:0] score_adj;
	logic                         wr_en;
	logic [IW-1:0]                wr_addr;
	entry_t                       wr_data;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	// Slot index is the top word of key times slots in use, built from two
	// 32-bit partial products.
	assign n_sat = ({15'd0, entries_q} > 32'(MAX_ENTRIES)) ? NW'(MAX_ENTRIES)
							       : NW'(entries_q);
	assign prod_hi_w = search_key[63:32] * n_sat;
	assign prod_lo_w = search_key[31:0] * n_sat;
	assign mid_w     = {1'b0, prod_hi_s1} + (PW + 1)'(prod_lo_s1[PW-1:TAG_BITS]);
	assign idx_w     = mid_w[TAG_BITS +: IW];

	assign hit_w = (rdata_s2.tag == tag_q) && (rdata_s2.bound != BOUND_NONE);

	// Mate scores move away from zero by ply on save and back toward zero on probe.
	always_comb begin
		sw    = save_q ? AW'(score_q) : AW'(rdata_s2.score);
		thr_w = signed'(AW'({1'b0, mate_q}));
		ply_w = signed'(AW'({1'b0, ply_q}));
		if (sw > thr_w) begin
			adj_w = save_q ? (sw + ply_w) : (sw - ply_w);
		end else if (sw < -thr_w) begin
			adj_w = save_q ? (sw - ply_w) : (sw + ply_w);
		end else begin
			adj_w = sw;
		end
		if (adj_w > SMAX) begin
			adj_w = SMAX;
		end else if (adj_w < SMIN) begin
			adj_w = SMIN;
		end
		score_adj = adj_w[SCORE_BITS-1:0];
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_s2;
		wr_data = '0;
		if (state_q == S_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_ptr_q;
		end else if (state_q == S_UPDATE && save_q) begin
			wr_en         = 1'b1;
			wr_data.tag   = tag_q;
			// A save without a move keeps the old move of the same position.
			wr_data.move  = (move_q != '0 || rdata_s2.tag != tag_q) ? move_q
										: rdata_s2.move;
			wr_data.score = score_adj;
			wr_data.depth = depth_q;
			wr_data.bound = bound_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_s2 <= mem[idx_w];
	end

	// Request word and partial products; no reset needed.
	always_ff @(posedge clk) begin
		if (accept) begin
			save_q     <= (kind == KIND_SAVE);
			tag_q      <= search_key[TAG_BITS-1:0];
			move_q     <= move_in;
			score_q    <= score_in;
			bound_q    <= bound_in;
			depth_q    <= depth_in;
			ply_q      <= ply;
			prod_hi_s1 <= prod_hi_w;
			prod_lo_s1 <= prod_lo_w;
		end
		if (state_q == S_READ) begin
			idx_s2 <= idx_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_ptr_q   <= '0;
			entries_q   <= RST_TABLE_ENTRIES;
			mate_q      <= RST_MATE_THRESHOLD;
			hits_q      <= '0;
			done_q      <= 1'b0;
			found_q     <= 1'b0;
			score_out_q <= '0;
			depth_out_q <= '0;
			move_out_q  <= '0;
			bound_out_q <= BOUND_NONE;
		end else begin
			done_q <= (state_q == S_UPDATE) && !save_q;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_TABLE_ENTRIES: entries_q <= cfg_data;
					CFG_MATE_THRESHOLD: mate_q <= cfg_data[MATE_BITS-1:0];
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (kind)
							KIND_PROBE, KIND_SAVE: state_q <= S_READ;
							KIND_CLEAR: begin
								state_q   <= S_CLEAR;
								clr_ptr_q <= '0;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_READ: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					state_q <= S_IDLE;
					if (!save_q) begin
						if (hit_w) begin
							hits_q      <= hits_q + HITS_BITS'(1);
							found_q     <= 1'b1;
							score_out_q <= score_adj;
							depth_out_q <= rdata_s2.depth;
							move_out_q  <= rdata_s2.move;
							bound_out_q <= rdata_s2.bound;
						end else begin
							found_q     <= 1'b0;
							score_out_q <= '0;
							depth_out_q <= '0;
							move_out_q  <= '0;
							bound_out_q <= BOUND_NONE;
						end
					end
				end
				S_CLEAR: begin
					if (clr_ptr_q == LAST_SLOT) begin
						state_q   <= S_IDLE;
						clr_ptr_q <= '0;
					end else begin
						clr_ptr_q <= clr_ptr_q + IW'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done      = done_q;
	assign found     = found_q;
	assign score_out = score_out_q;
	assign depth_out = depth_out_q;
	assign move_out  = move_out_q;
	assign bound_out = bound_out_q;
	assign hits      = hits_q;

	// A result word only ever follows the update step of a probe.
	a_done_after_probe: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == S_UPDATE) && !$past(save_q))
		else $error("result strobe without a probe update");

	// The hit count moves only together with a reported hit.
	a_hits_with_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(hits_q != $past(hits_q)) |-> (done_q && found_q &&
			hits_q == $past(hits_q) + HITS_BITS'(1)))
		else $error("hit count changed without a hit");

	// A hit never reports an empty bound.
	a_hit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && found_q) |-> (bound_out_q != BOUND_NONE))
		else $error("hit with bound none");

	// The clear sweep steps through the table one slot per cycle.
	a_clear_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR && clr_ptr_q != LAST_SLOT) |=>
			(state_q == S_CLEAR && clr_ptr_q == $past(clr_ptr_q) + IW'(1)))
		else $error("clear sweep skipped or stopped early");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import hth_pkg::*;

	localparam int unsigned NSLOTS = DEF_MAX_ENTRIES;
	localparam int unsigned SB = DEF_SCORE_BITS;
	localparam int unsigned MB = DEF_MOVE_BITS;
	localparam int SCORE_HI = (1 <<< (SB - 1)) - 1;
	localparam int SCORE_LO = -SCORE_HI - 1;
	localparam int unsigned RUN_LIMIT = 2000000;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam logic [KEY_BITS-1:0] KEY_A = 64'h0123_4567_89AB_CDEF;
	localparam logic [KEY_BITS-1:0] KEY_B = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [KEY_BITS-1:0] KEY_C = 64'h0123_4567_5555_AAAA;
	localparam logic [KEY_BITS-1:0] KEY_D = 64'hFEDC_BA98_7654_3210;

	typedef struct packed {
		logic                   found;
		logic signed [SB-1:0]   score;
		logic [DEPTH_BITS-1:0]  depth;
		logic [MB-1:0]          move;
		logic [1:0]             bound;
		logic [HITS_BITS-1:0]   hits;
	} probe_answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] kind = KIND_PROBE;
	logic [KEY_BITS-1:0] search_key = '0;
	logic [MB-1:0] move_in = '0;
	logic signed [SB-1:0] score_in = '0;
	logic [1:0] bound_in = BOUND_NONE;
	logic [DEPTH_BITS-1:0] depth_in = '0;
	logic [PLY_BITS-1:0] ply = '0;
	logic done;
	logic found;
	logic signed [SB-1:0] score_out;
	logic [DEPTH_BITS-1:0] depth_out;
	logic [MB-1:0] move_out;
	logic [1:0] bound_out;
	logic [HITS_BITS-1:0] hits;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = CFG_TABLE_ENTRIES;
	logic [ENTRY_BITS-1:0] cfg_data = '0;

	hashed_transposition_table_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.search_key (search_key),
		.move_in    (move_in),
		.score_in   (score_in),
		.bound_in   (bound_in),
		.depth_in   (depth_in),
		.ply        (ply),
		.done       (done),
		.found      (found),
		.score_out  (score_out),
		.depth_out  (depth_out),
		.move_out   (move_out),
		.bound_out  (bound_out),
		.hits       (hits),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// Shadow copy of the table, its hit counter and its configuration.
	logic [TAG_BITS-1:0] tt_tag [NSLOTS];
	logic [MB-1:0] tt_move [NSLOTS];
	logic signed [SB-1:0] tt_score [NSLOTS];
	logic [DEPTH_BITS-1:0] tt_depth [NSLOTS];
	logic [1:0] tt_bound [NSLOTS];
	logic [HITS_BITS-1:0] hit_total = '0;
	logic [ENTRY_BITS-1:0] slot_count = RST_TABLE_ENTRIES;
	logic [MATE_BITS-1:0] mate_limit = RST_MATE_THRESHOLD;

	probe_answer_t probe_answers [$];
	logic [KEY_BITS-1:0] key_pool [$];
	bit gaps_on = 1'b1;
	int mismatches = 0;
	int n_probes = 0;
	int n_hits = 0;
	int n_saves = 0;
	int n_clears = 0;
	int n_ignored = 0;
	int n_settings = 0;
	int unsigned cycle_count = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic void wipe_shadow();
		for (int i = 0; i < NSLOTS; i++) begin
			tt_tag[i] = '0;
			tt_move[i] = '0;
			tt_score[i] = '0;
			tt_depth[i] = '0;
			tt_bound[i] = BOUND_NONE;
		end
	endfunction

	function automatic int clamp_score(int s);
		if (s > SCORE_HI)
			return SCORE_HI;
		if (s < SCORE_LO)
			return SCORE_LO;
		return s;
	endfunction

	// The slot is the top part of key times the slots in use, as a fixed-point scale.
	function automatic int unsigned slot_of_key(logic [KEY_BITS-1:0] key);
		logic [ENTRY_BITS-1:0] n;
		logic [KEY_BITS+ENTRY_BITS-1:0] prod;
		n = (slot_count > NSLOTS) ? ENTRY_BITS'(NSLOTS) : slot_count;
		prod = key * n;
		return int'((prod >> KEY_BITS) % NSLOTS);
	endfunction

	function automatic void table_update(logic [1:0] k, logic [KEY_BITS-1:0] key,
			logic [MB-1:0] mv, logic signed [SB-1:0] sc, logic [1:0] bd,
			logic [DEPTH_BITS-1:0] dp, logic [PLY_BITS-1:0] pl);
		int unsigned idx;
		logic [TAG_BITS-1:0] tag;
		int s;
		int thr;
		int p;
		probe_answer_t ans;
		idx = slot_of_key(key);
		tag = key[TAG_BITS-1:0];
		thr = int'(mate_limit);
		p = int'(pl);
		case (k)
		KIND_CLEAR: begin
			wipe_shadow();
			n_clears++;
		end
		KIND_SAVE: begin
			s = sc;
			if (s > thr)
				s = clamp_score(s + p);
			else if (s < -thr)
				s = clamp_score(s - p);
			if (mv != '0 || tt_tag[idx] != tag)
				tt_move[idx] = mv;
			tt_tag[idx] = tag;
			tt_bound[idx] = bd;
			tt_score[idx] = SB'(s);
			tt_depth[idx] = dp;
			n_saves++;
		end
		KIND_PROBE: begin
			ans = '0;
			if (tt_tag[idx] == tag && tt_bound[idx] != BOUND_NONE) begin
				s = tt_score[idx];
				if (s > thr)
					s = clamp_score(s - p);
				else if (s < -thr)
					s = clamp_score(s + p);
				hit_total = hit_total + 1'b1;
				ans.found = 1'b1;
				ans.score = SB'(s);
				ans.depth = tt_depth[idx];
				ans.move = tt_move[idx];
				ans.bound = tt_bound[idx];
				n_hits++;
			end
			ans.hits = hit_total;
			probe_answers.push_back(ans);
			n_probes++;
		end
		default: begin
			n_ignored++;
		end
		endcase
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic logic signed [SB-1:0] pick_score();
		int v;
		case ($urandom_range(0, 9))
		0: begin
			v = SCORE_HI;
		end
		1: begin
			v = SCORE_LO;
		end
		2, 3, 4: begin
			// Straddle the mate threshold on either side of zero.
			v = int'(mate_limit) + int'($urandom_range(0, 400)) - 200;
			if (v > SCORE_HI)
				v = SCORE_HI;
			if (v < 0)
				v = 0;
			if ($urandom_range(0, 1))
				v = -v;
		end
		default: begin
			v = int'($urandom_range(0, 65535)) + SCORE_LO;
		end
		endcase
		return SB'(v);
	endfunction

	// Start stays high when the next word follows at once, so it is never
	// lowered and raised in the same step.
	task automatic send_word(input logic [1:0] k, input logic [KEY_BITS-1:0] key,
			input logic [MB-1:0] mv, input logic signed [SB-1:0] sc,
			input logic [1:0] bd, input logic [DEPTH_BITS-1:0] dp,
			input logic [PLY_BITS-1:0] pl);
		int unsigned gap;
		gap = gaps_on ? pick_gap() : 0;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		kind <= k;
		search_key <= key;
		move_in <= mv;
		score_in <= sc;
		bound_in <= bd;
		depth_in <= dp;
		ply <= pl;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		table_update(k, key, mv, sc, bd, dp, pl);
	endtask

	task automatic probe_key(input logic [KEY_BITS-1:0] key, input logic [PLY_BITS-1:0] pl);
		send_word(KIND_PROBE, key, MB'($urandom), SB'($urandom), BOUND_NONE, '0, pl);
	endtask

	// Wait until every probe has answered and the last save or clear has drained.
	task automatic settle();
		start <= 1'b0;
		while (probe_answers.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic set_table_config(input logic [ENTRY_BITS-1:0] entries,
			input logic [ENTRY_BITS-1:0] mate_word);
		cfg_index <= CFG_TABLE_ENTRIES;
		cfg_data <= entries;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		slot_count = entries;
		cfg_index <= CFG_MATE_THRESHOLD;
		cfg_data <= mate_word;
		do @(posedge clk); while (!cfg_ready);
		mate_limit = mate_word[MATE_BITS-1:0];
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	always @(posedge clk) begin : check_results
		probe_answer_t want;
		if (arst_n && done) begin
			if (probe_answers.size() == 0) begin
				$error("result word with no probe waiting, hits=%0d", hits);
				mismatches++;
			end else begin
				want = probe_answers.pop_front();
				if (found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, found);
					mismatches++;
				end
				if (score_out !== want.score) begin
					$error("score_out: expected %0d, got %0d", want.score, score_out);
					mismatches++;
				end
				if (depth_out !== want.depth) begin
					$error("depth_out: expected %0d, got %0d", want.depth, depth_out);
					mismatches++;
				end
				if (move_out !== want.move) begin
					$error("move_out: expected %h, got %h", want.move, move_out);
					mismatches++;
				end
				if (bound_out !== want.bound) begin
					$error("bound_out: expected %0d, got %0d", want.bound, bound_out);
					mismatches++;
				end
				if (hits !== want.hits) begin
					$error("hits: expected %0d, got %0d", want.hits, hits);
					mismatches++;
				end
			end
		end
	end

	task automatic test_empty_table();
		gaps_on = 1'b1;
		// Key zero matches the reset tag, but the bound is none.
		probe_key('0, 8'd0);
		probe_key(KEY_B, 8'd255);
		send_word(KIND_UNUSED, KEY_A, '1, '1, BOUND_EXACT, '1, '1);
		settle();
	endtask

	task automatic test_save_and_probe();
		set_table_config(RST_TABLE_ENTRIES, ENTRY_BITS'(RST_MATE_THRESHOLD));
		// A mate score at the top of the range saturates when pushed out by ply.
		send_word(KIND_SAVE, KEY_A, '1, SB'(SCORE_HI), BOUND_EXACT, 8'd255, 8'd255);
		probe_key(KEY_A, 8'd0);
		probe_key(KEY_A, 8'd255);
		send_word(KIND_SAVE, KEY_B, '0, SB'(SCORE_LO), BOUND_UPPER, 8'd0, 8'd255);
		probe_key(KEY_B, 8'd17);
		// No new move for the same position keeps the stored move.
		send_word(KIND_SAVE, KEY_A, '0, 16'sd31001, BOUND_LOWER, 8'd9, 8'd3);
		probe_key(KEY_A, 8'd3);
		// Same slot with another tag replaces the entry.
		send_word(KIND_SAVE, KEY_C, 32'd5, 16'sd100, BOUND_EXACT, 8'd4, 8'd0);
		probe_key(KEY_A, 8'd0);
		probe_key(KEY_C, 8'd0);
		probe_key({~KEY_C[63:32], KEY_C[31:0]}, 8'd0);
		// An entry saved with bound none never hits.
		send_word(KIND_SAVE, '0, 32'h8000_0000, -16'sd31001, BOUND_NONE, 8'h80, 8'h7F);
		probe_key('0, 8'h7F);
		// A score equal to the threshold is not treated as a mate score.
		send_word(KIND_SAVE, KEY_B, 32'd77, 16'sd31000, BOUND_EXACT, 8'd1, 8'd200);
		probe_key(KEY_B, 8'd200);
		send_word(KIND_UNUSED, KEY_C, '1, '1, BOUND_NONE, '1, '1);
		probe_key(KEY_C, 8'd1);
		settle();
	endtask

	task automatic test_table_size();
		// With no slots in use every key lands in slot zero.
		set_table_config('0, ENTRY_BITS'(RST_MATE_THRESHOLD));
		send_word(KIND_SAVE, KEY_D, 32'hDEAD_BEEF, -16'sd31500, BOUND_LOWER, 8'd12, 8'd40);
		probe_key(KEY_D, 8'd40);
		probe_key(KEY_A, 8'd0);
		settle();
		// A count above the table size saturates to the full table.
		set_table_config('1, ENTRY_BITS'(RST_MATE_THRESHOLD));
		probe_key(KEY_C, 8'd0);
		probe_key(KEY_D, 8'd0);
		settle();
	endtask

	task automatic test_clear();
		send_word(KIND_CLEAR, {$urandom, $urandom}, MB'($urandom), SB'($urandom),
			BOUND_EXACT, '1, '1);
		probe_key(KEY_C, 8'd0);
		probe_key('0, 8'd0);
		settle();
	endtask

	task automatic random_request(output bit counted);
		logic [KEY_BITS-1:0] key;
		logic [1:0] k;
		logic [MB-1:0] mv;
		logic [1:0] bd;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 40)
			k = KIND_SAVE;
		else if (r < 97)
			k = KIND_PROBE;
		else
			k = KIND_UNUSED;
		counted = (k != KIND_UNUSED);
		r = $urandom_range(0, 99);
		if (key_pool.size() == 0 || r < 25) begin
			key = {$urandom, $urandom};
			if (k == KIND_SAVE) begin
				key_pool.push_back(key);
				if (key_pool.size() > 48)
					void'(key_pool.pop_front());
			end
		end else begin
			key = key_pool[$urandom_range(0, key_pool.size() - 1)];
			// Near misses: the same tag elsewhere, or another tag in the same slot.
			if (r < 35)
				key[63:32] = $urandom;
			else if (r < 45)
				key[31:0] = $urandom;
		end
		mv = ($urandom_range(0, 4) == 0) ? '0 : MB'($urandom);
		if ($urandom_range(0, 9) == 0)
			bd = BOUND_NONE;
		else
			bd = 2'($urandom_range(BOUND_EXACT, BOUND_UPPER));
		send_word(k, key, mv, pick_score(), bd, DEPTH_BITS'($urandom), PLY_BITS'($urandom));
	endtask

	task automatic test_random_traffic(input logic [ENTRY_BITS-1:0] entries,
			input logic [MATE_BITS-1:0] mate, input int count, input bit with_clear,
			input bit idle_gaps);
		int sent;
		bit counted;
		settle();
		// The bits above the threshold width are written at random; the register drops them.
		set_table_config(entries, {2'($urandom), mate});
		gaps_on = idle_gaps;
		if (with_clear)
			send_word(KIND_CLEAR, {$urandom, $urandom}, MB'($urandom), SB'($urandom),
				2'($urandom), DEPTH_BITS'($urandom), PLY_BITS'($urandom));
		sent = 0;
		while (sent < count) begin
			random_request(counted);
			if (counted)
				sent++;
		end
		settle();
	endtask

	initial begin
		wipe_shadow();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_table();
		test_save_and_probe();
		test_table_size();
		test_clear();
		test_random_traffic(17'd65536, 15'd31000, 275, 1'b0, 1'b1);
		test_random_traffic(17'd1, 15'd0, 250, 1'b1, 1'b1);
		test_random_traffic(17'd0, 15'd32767, 225, 1'b0, 1'b0);
		test_random_traffic(17'd131071, 15'd100, 250, 1'b0, 1'b1);
		test_random_traffic(17'd300, 15'd30000, 250, 1'b1, 1'b1);
		test_random_traffic(17'd65535, 15'($urandom), 250, 1'b0, 1'b0);
		test_random_traffic(17'($urandom_range(2, 2048)), 15'($urandom), 225, 1'b0, 1'b1);
		settle();
		repeat (8) @(posedge clk);
		$display("Covered %0d probes with %0d hits, %0d saves, %0d clears, %0d ignored words,",
			n_probes, n_hits, n_saves, n_clears, n_ignored);
		$display("across %0d table size and threshold settings, with and without idle gaps.",
			n_settings);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
